>>> hdl/lcgsr_pkg.sv
// ----------------------------------------------------------------------------
// lcgsr_pkg
// Shared types and constants of the truncated-output LCG seed recovery core.
// ----------------------------------------------------------------------------
package lcgsr_pkg;

    // search kinds
    localparam logic [1:0] FUNC_IV      = 2'd0;
    localparam logic [1:0] FUNC_PID     = 2'd1;
    localparam logic [1:0] FUNC_CHANNEL = 2'd2;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam int MW = 30;  // divisor width
    localparam int TW = 58;  // walk value width, holds base plus one step

    // generator
    localparam logic [31:0] LCG_MULT = 32'h0003_43FD;
    localparam logic [31:0] LCG_ADD  = 32'h0026_9EC3;

    // plain constant set
    localparam logic [MW-1:0] MUL0  = 30'h0003_43FD;
    localparam logic [31:0]   SUB0  = 32'h0025_9EC4;
    localparam logic [TW-1:0] BASE0 = 58'h0_0003_43FA_BC02;
    // five-step constant set
    localparam logic [MW-1:0] MUL1  = 30'h284A_930D;
    localparam logic [31:0]   SUB1  = 32'h9A97_4C78;
    localparam logic [TW-1:0] BASE1 = 58'h142_5498_47B5_6CF2;

    localparam logic [63:0] STEP31 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] STEP32 = 64'h0000_0001_0000_0000;

    // quotient and remainder of one walk step by each multiplier; the 2^32
    // quotients also serve as reciprocals for the start division
    localparam logic [31:0]   QS0_31 = 32'(STEP31 / {34'd0, MUL0});
    localparam logic [MW-1:0] RS0_31 = MW'(STEP31 % {34'd0, MUL0});
    localparam logic [31:0]   QS0_32 = 32'(STEP32 / {34'd0, MUL0});
    localparam logic [MW-1:0] RS0_32 = MW'(STEP32 % {34'd0, MUL0});
    localparam logic [31:0]   QS1_31 = 32'(STEP31 / {34'd0, MUL1});
    localparam logic [MW-1:0] RS1_31 = MW'(STEP31 % {34'd0, MUL1});
    localparam logic [31:0]   QS1_32 = 32'(STEP32 / {34'd0, MUL1});
    localparam logic [MW-1:0] RS1_32 = MW'(STEP32 % {34'd0, MUL1});

    localparam logic [MW-1:0] BOUND_PAIR    = 30'h0001_0000;
    localparam logic [MW-1:0] BOUND_CHANNEL = 30'h0800_0000;

    typedef struct packed {
        logic load_in;
        logic mult;
        logic init;
        logic recip;
        logic mulback;
        logic fix;
        logic advance;
        logic lcg_first;
        logic lcg_step;
        logic store;
        logic push_pend;
        logic push_final;
        logic set_ovf;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       t_over;
        logic       rem_ok;
        logic       n_full;
        logic       pend_valid;
        logic       out_free;
        logic       chk_match;
        logic       chk_last;
    } stat_t;

    function automatic logic [31:0] lcg_next(input logic [31:0] s);
        lcg_next = s * LCG_MULT + LCG_ADD;
    endfunction

endpackage

>>> hdl/lcg_truncated_seed_recovery_core.sv
// ----------------------------------------------------------------------------
// lcg_truncated_seed_recovery_core
// Recovers full LCG seeds from truncated outputs by a stepped division walk.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one transfer starts one search; the
// core stalls its input until the last result of that search is in the
// output register. Output channel (out_valid / out_stall): one transfer per
// result, the final one of a search with last set. The output register lets
// the next search start while a result still waits.
// Configuration (cfg_valid / cfg_ready): constant_set, always ready; write it
// only between searches.
// Sequence: setup (product, start value and a reciprocal division of the start
// value by estimate, multiply-back and correction), then the walk steps k (kmax
// + 1 steps) and a check that ends the walk; in pair searches each accepted
// candidate is stored, and in the Channel search a candidate within the bound
// first takes one to four generator checks. The final result then goes to the
// output register. The walk runs at one step a cycle while no candidate holds
// it up, and is what sets throughput.
// Reset clears constant_set, the sequencer and the output valid.
// A stalled output holds its result; the search waits when a new candidate
// needs the output register and it is still full.
// ----------------------------------------------------------------------------
module lcg_truncated_seed_recovery_core #(
    parameter int MAX_RESULTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        constant_set,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] first_call,
    input  logic [31:0] second_call,
    input  logic [4:0]  value_hp,
    input  logic [4:0]  value_atk,
    input  logic [4:0]  value_def,
    input  logic [4:0]  value_spa,
    input  logic [4:0]  value_spd,
    input  logic [4:0]  value_spe,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [31:0] seed,
    output logic [31:0] next_seed,
    output logic        last,
    output logic        overflow
);

    lcgsr_pkg::cmd_t  cmd;
    lcgsr_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    lcgsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lcgsr_datapath #(
        .MAX_RESULTS (MAX_RESULTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (constant_set),
        .func        (func),
        .first_call  (first_call),
        .second_call (second_call),
        .value_hp    (value_hp),
        .value_atk   (value_atk),
        .value_def   (value_def),
        .value_spa   (value_spa),
        .value_spd   (value_spd),
        .value_spe   (value_spe),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .found       (found),
        .seed        (seed),
        .next_seed   (next_seed),
        .last        (last),
        .overflow    (overflow)
    );

endmodule

>>> hdl/lcgsr_datapath.sv
// ----------------------------------------------------------------------------
// lcgsr_datapath
// Operand registers, reciprocal divider, walk update, generator steps and the
// pending and output result registers.
// ----------------------------------------------------------------------------
module lcgsr_datapath #(
    parameter int MAX_RESULTS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcgsr_pkg::cmd_t      cmd,
    output lcgsr_pkg::stat_t     stat,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic [1:0]           func,
    input  logic [31:0]          first_call,
    input  logic [31:0]          second_call,
    input  logic [4:0]           value_hp,
    input  logic [4:0]           value_atk,
    input  logic [4:0]           value_def,
    input  logic [4:0]           value_spa,
    input  logic [4:0]           value_spd,
    input  logic [4:0]           value_spe,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic                 found,
    output logic [31:0]          seed,
    output logic [31:0]          next_seed,
    output logic                 last,
    output logic                 overflow
);

    localparam int MW = lcgsr_pkg::MW;
    localparam int TW = lcgsr_pkg::TW;
    localparam int NW = $clog2(MAX_RESULTS + 1);

    logic            set_reg;
    logic [1:0]      func_reg;
    logic [31:0]     a_reg;
    logic [31:0]     f_reg;
    logic [4:0]      v_reg [4];
    logic [31:0]     prod_reg;
    logic [31:0]     dvd_reg;
    logic [TW-1:0]   t_reg;
    logic [31:0]     q_reg;
    logic [MW-1:0]   r_reg;
    logic [31:0]     c_reg;
    logic [1:0]      chk_reg;
    logic            pend_valid_reg;
    logic [31:0]     pend_seed_reg;
    logic [31:0]     pend_next_reg;
    logic [NW-1:0]   n_reg;
    logic            ovf_reg;
    logic            out_valid_reg;
    logic            found_reg;
    logic [31:0]     seed_reg;
    logic [31:0]     next_reg;
    logic            last_reg;
    logic            overflow_reg;

    logic [MW-1:0]   mul;
    logic [31:0]     sub;
    logic [TW-1:0]   base;
    logic [31:0]     qs;
    logic [MW-1:0]   rs;
    logic [31:0]     rcp;
    logic [31:0]     q_est;
    logic            dvd_ge;
    logic [31:0]     dvd_fix;
    logic [MW-1:0]   bound;
    logic [31:0]     t0;
    logic [MW:0]     r_sum;
    logic            r_wrap;
    logic [TW-1:0]   t_next;
    logic [31:0]     cand;
    logic            out_free;

    always_comb
    begin
        mul  = set_reg ? lcgsr_pkg::MUL1  : lcgsr_pkg::MUL0;
        sub  = set_reg ? lcgsr_pkg::SUB1  : lcgsr_pkg::SUB0;
        base = set_reg ? lcgsr_pkg::BASE1 : lcgsr_pkg::BASE0;
        rcp  = set_reg ? lcgsr_pkg::QS1_32 : lcgsr_pkg::QS0_32;
        if (func_reg == lcgsr_pkg::FUNC_IV)
        begin
            qs     = set_reg ? lcgsr_pkg::QS1_31 : lcgsr_pkg::QS0_31;
            rs     = set_reg ? lcgsr_pkg::RS1_31 : lcgsr_pkg::RS0_31;
            t_next = t_reg + TW'(lcgsr_pkg::STEP31);
        end
        else
        begin
            qs     = set_reg ? lcgsr_pkg::QS1_32 : lcgsr_pkg::QS0_32;
            rs     = set_reg ? lcgsr_pkg::RS1_32 : lcgsr_pkg::RS0_32;
            t_next = t_reg + TW'(lcgsr_pkg::STEP32);
        end
        bound = (func_reg == lcgsr_pkg::FUNC_CHANNEL) ? lcgsr_pkg::BOUND_CHANNEL
                                                     : lcgsr_pkg::BOUND_PAIR;
        t0 = a_reg - prod_reg - sub;
        if (func_reg == lcgsr_pkg::FUNC_IV)
        begin
            t0[31] = 1'b0;
        end
        // estimate is the true quotient or one below it
        q_est     = 32'(({32'd0, dvd_reg} * {32'd0, rcp}) >> 32);
        dvd_ge    = dvd_reg >= {2'd0, mul};
        dvd_fix   = dvd_reg - {2'd0, mul};
        r_sum     = {1'b0, r_reg} + {1'b0, rs};
        r_wrap    = r_sum >= {1'b0, mul};
        cand      = f_reg | q_reg;
        out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        stat.func       = func_reg;
        stat.t_over     = t_reg > base;
        stat.rem_ok     = r_reg < bound;
        stat.n_full     = n_reg == NW'(MAX_RESULTS);
        stat.pend_valid = pend_valid_reg;
        stat.out_free   = out_free;
        stat.chk_match  = c_reg[31:27] == v_reg[chk_reg];
        stat.chk_last   = chk_reg == 2'd3;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            n_reg          <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            chk_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                set_reg <= cfg_data;
            end
            if (cmd.lcg_first)
            begin
                chk_reg <= '0;
            end
            else if (cmd.lcg_step)
            begin
                chk_reg <= chk_reg + 2'd1;
            end
            if (cmd.load_in)
            begin
                pend_valid_reg <= 1'b0;
                n_reg          <= '0;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                if (cmd.store)
                begin
                    pend_valid_reg <= 1'b1;
                    n_reg          <= n_reg + NW'(1);
                end
                else if (cmd.push_final)
                begin
                    pend_valid_reg <= 1'b0;
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.push_pend || cmd.push_final)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= func;
            if (func == lcgsr_pkg::FUNC_CHANNEL)
            begin
                a_reg <= {value_spd, 27'd0};
                f_reg <= {value_hp, 27'd0};
            end
            else
            begin
                a_reg <= second_call;
                f_reg <= first_call;
            end
            v_reg[0] <= value_atk;
            v_reg[1] <= value_def;
            v_reg[2] <= value_spe;
            v_reg[3] <= value_spa;
        end
        if (cmd.mult)
        begin
            prod_reg <= 32'({2'd0, mul} * f_reg);
        end
        if (cmd.init)
        begin
            t_reg   <= {(TW - 32)'(0), t0};
            dvd_reg <= t0;
        end
        else if (cmd.recip)
        begin
            q_reg <= q_est;
        end
        else if (cmd.mulback)
        begin
            dvd_reg <= dvd_reg - 32'(q_reg * {2'd0, mul});
        end
        else if (cmd.fix)
        begin
            if (dvd_ge)
            begin
                r_reg <= dvd_fix[MW-1:0];
                q_reg <= q_reg + 32'd1;
            end
            else
            begin
                r_reg <= dvd_reg[MW-1:0];
            end
        end
        else if (cmd.advance)
        begin
            t_reg <= t_next;
            if (r_wrap)
            begin
                r_reg <= MW'(r_sum - {1'b0, mul});
                q_reg <= q_reg + qs + 32'd1;
            end
            else
            begin
                r_reg <= r_sum[MW-1:0];
                q_reg <= q_reg + qs;
            end
        end
        if (cmd.lcg_first)
        begin
            c_reg <= lcgsr_pkg::lcg_next(cand);
        end
        else if (cmd.lcg_step)
        begin
            c_reg <= lcgsr_pkg::lcg_next(c_reg);
        end
        if (cmd.store)
        begin
            pend_seed_reg <= cand;
            pend_next_reg <= (func_reg == lcgsr_pkg::FUNC_CHANNEL) ? 32'd0 : c_reg;
        end
        if (cmd.push_pend)
        begin
            found_reg    <= 1'b1;
            seed_reg     <= pend_seed_reg;
            next_reg     <= pend_next_reg;
            last_reg     <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.push_final)
        begin
            found_reg    <= pend_valid_reg;
            seed_reg     <= pend_valid_reg ? pend_seed_reg : 32'd0;
            next_reg     <= pend_valid_reg ? pend_next_reg : 32'd0;
            last_reg     <= 1'b1;
            overflow_reg <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign seed      = seed_reg;
    assign next_seed = next_reg;
    assign last      = last_reg;
    assign overflow  = overflow_reg;

endmodule

>>> hdl/lcgsr_ctrl.sv
// ----------------------------------------------------------------------------
// lcgsr_ctrl
// Sequencer of one search: setup, division, walk, candidate checks, results.
// ----------------------------------------------------------------------------
module lcgsr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lcgsr_pkg::stat_t  stat,
    output lcgsr_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULT,
        ST_INIT,
        ST_RECIP,
        ST_BACK,
        ST_FIX,
        ST_CHECK,
        ST_TEST,
        ST_STORE,
        ST_FINAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = (stat.func == lcgsr_pkg::FUNC_UNUSED) ? ST_FINAL : ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_BACK;
            end
            ST_BACK:
            begin
                cmd.mulback = 1'b1;
                state_next  = ST_FIX;
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.t_over)
                begin
                    state_next = ST_FINAL;
                end
                else if (!stat.rem_ok)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.lcg_first = 1'b1;
                    state_next = (stat.func == lcgsr_pkg::FUNC_CHANNEL) ? ST_TEST : ST_STORE;
                end
            end
            ST_TEST:
            begin
                if (!stat.chk_match)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_CHECK;
                end
                else if (stat.chk_last)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    cmd.lcg_step = 1'b1;
                end
            end
            ST_STORE:
            begin
                if (stat.n_full)
                begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_FINAL;
                end
                else if (!stat.pend_valid || stat.out_free)
                begin
                    // hand the previous candidate on, keep this one
                    cmd.push_pend = stat.pend_valid;
                    cmd.store     = 1'b1;
                    cmd.advance   = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    cmd.push_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != ST_IDLE;

endmodule

>>> hdl/lcgsr_checker.sv
// ----------------------------------------------------------------------------
// lcgsr_checker
// Port-level checks of the seed recovery core, bound to the top level.
// ----------------------------------------------------------------------------
module lcgsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [31:0] seed,
    input logic [31:0] next_seed,
    input logic        last,
    input logic        overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(seed) && $stable(last))
        else $error("stalled result changed");

    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last)
        else $error("not-found result without last");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> seed == 32'd0 && next_seed == 32'd0 && !overflow)
        else $error("not-found result carries data");

    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> last && found)
        else $error("overflow off the final result");

endmodule

bind lcg_truncated_seed_recovery_core lcgsr_checker u_lcgsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .seed      (seed),
    .next_seed (next_seed),
    .last      (last),
    .overflow  (overflow)
);

>>> dv/tb_lcg_truncated_seed_recovery_core.sv
// ----------------------------------------------------------------------------
// tb_lcg_truncated_seed_recovery_core
// Drives IV, PID and Channel seed searches under constant set 0 and a PID search
// under set 1, with random bursts on the search input and random stalls on the
// result output, and checks every result against a local model of the walk.
// ----------------------------------------------------------------------------
module tb_lcg_truncated_seed_recovery_core;

    localparam int LIMIT_RESULTS = 64;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] first_call;
        logic [31:0] second_call;
        logic [4:0]  hp;
        logic [4:0]  atk;
        logic [4:0]  def;
        logic [4:0]  spa;
        logic [4:0]  spd;
        logic [4:0]  spe;
    } search_t;

    typedef struct {
        logic        found;
        logic [31:0] seed;
        logic [31:0] next_seed;
        logic        last;
        logic        overflow;
    } seed_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        constant_set;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] first_call;
    logic [31:0] second_call;
    logic [4:0]  value_hp;
    logic [4:0]  value_atk;
    logic [4:0]  value_def;
    logic [4:0]  value_spa;
    logic [4:0]  value_spd;
    logic [4:0]  value_spe;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic [31:0] seed;
    logic [31:0] next_seed;
    logic        last;
    logic        overflow;

    search_t      pending_searches[$];
    seed_result_t expected_seeds[$];
    search_t      drive_item;
    logic         in_taken;
    logic         set_sel;
    int           errors;
    int           idle_cycles;
    int           burst_left;
    int           gap_left;
    int           stall_pct;
    int           stall_cycles;

    lcg_truncated_seed_recovery_core #(
        .MAX_RESULTS(LIMIT_RESULTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .constant_set(constant_set),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .first_call(first_call),
        .second_call(second_call),
        .value_hp(value_hp),
        .value_atk(value_atk),
        .value_def(value_def),
        .value_spa(value_spa),
        .value_spd(value_spd),
        .value_spe(value_spe),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .seed(seed),
        .next_seed(next_seed),
        .last(last),
        .overflow(overflow)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] step_seed(input logic [31:0] s);
        return s * 32'h0003_43FD + 32'h0026_9EC3;
    endfunction

    function automatic void add_search(input search_t it);
        pending_searches.insert(pending_searches.size(), it);
    endfunction

    // Walk t = t0 + k*step and queue one result per kept candidate, or one not-found result.
    function automatic void predict_search(input search_t it);
        logic [31:0]  mulv;
        logic [31:0]  subv;
        logic [63:0]  basev;
        logic [63:0]  stepv;
        logic [63:0]  t;
        logic [63:0]  kmax;
        logic [31:0]  top;
        logic [31:0]  s;
        logic [31:0]  c;
        logic [31:0]  t32;
        logic         ovf;
        logic         pass;
        seed_result_t res;
        seed_result_t hits[$];

        ovf = 1'b0;
        mulv = set_sel ? 32'h284A_930D : 32'h0003_43FD;
        subv = set_sel ? 32'h9A97_4C78 : 32'h0025_9EC4;
        basev = set_sel ? 64'h0142_5498_47B5_6CF2 : 64'h0000_0003_43FA_BC02;
        if (it.func == lcgsr_pkg::FUNC_IV || it.func == lcgsr_pkg::FUNC_PID)
        begin
            t32 = it.second_call - mulv * it.first_call - subv;
            t = {32'd0, t32};
            if (it.func == lcgsr_pkg::FUNC_IV)
            begin
                t = t & 64'h7FFF_FFFF;
                stepv = 64'h8000_0000;
            end
            else
            begin
                stepv = 64'h1_0000_0000;
            end
            kmax = (basev - t) / stepv;
            for (logic [63:0] k = 0; k <= kmax; k++)
            begin
                if (t % {32'd0, mulv} < 64'h1_0000)
                begin
                    if (hits.size() >= LIMIT_RESULTS)
                    begin
                        ovf = 1'b1;
                        break;
                    end
                    s = it.first_call | 32'(t / {32'd0, mulv});
                    res = '{1'b1, s, step_seed(s), 1'b0, 1'b0};
                    hits.insert(hits.size(), res);
                end
                t += stepv;
            end
        end
        else if (it.func == lcgsr_pkg::FUNC_CHANNEL)
        begin
            top = {it.hp, 27'd0};
            stepv = 64'h1_0000_0000;
            t32 = {it.spd, 27'd0} - mulv * top - subv;
            t = {32'd0, t32};
            kmax = (basev - t) / stepv;
            for (logic [63:0] k = 0; k <= kmax; k++)
            begin
                if (t % {32'd0, mulv} < 64'h800_0000)
                begin
                    s = top | 32'(t / {32'd0, mulv});
                    c = step_seed(s);
                    pass = (c[31:27] == it.atk);
                    c = step_seed(c);
                    pass = pass && (c[31:27] == it.def);
                    c = step_seed(c);
                    pass = pass && (c[31:27] == it.spe);
                    c = step_seed(c);
                    pass = pass && (c[31:27] == it.spa);
                    if (pass)
                    begin
                        if (hits.size() >= LIMIT_RESULTS)
                        begin
                            ovf = 1'b1;
                            break;
                        end
                        res = '{1'b1, s, 32'd0, 1'b0, 1'b0};
                        hits.insert(hits.size(), res);
                    end
                end
                t += stepv;
            end
        end
        if (hits.size() == 0)
        begin
            res = '{1'b0, 32'd0, 32'd0, 1'b0, 1'b0};
            hits.insert(hits.size(), res);
        end
        hits[hits.size() - 1].last = 1'b1;
        hits[hits.size() - 1].overflow = ovf;
        foreach (hits[i])
            expected_seeds.insert(expected_seeds.size(), hits[i]);
    endfunction

    function automatic search_t make_search(input logic [1:0] f, input logic [31:0] a,
                                            input logic [31:0] b, input logic [29:0] v);
        search_t it;
        it.func = f;
        it.first_call = a;
        it.second_call = b;
        {it.hp, it.atk, it.def, it.spa, it.spd, it.spe} = v;
        return it;
    endfunction

    // Well-formed search built from a real seed, or plain noise.
    function automatic search_t random_search();
        logic [31:0] s;
        logic [31:0] c1;
        logic [31:0] c2;
        logic [31:0] c3;
        logic [31:0] c4;
        logic [31:0] c5;
        logic [1:0]  f;
        int          pick;
        s = $urandom;
        c1 = step_seed(s);
        c2 = step_seed(c1);
        c3 = step_seed(c2);
        c4 = step_seed(c3);
        c5 = step_seed(c4);
        pick = $urandom_range(0, 9);
        f = 2'($urandom_range(0, 3));
        if (pick < 3)
        begin
            return make_search(lcgsr_pkg::FUNC_PID, s & 32'hFFFF_0000, c1 & 32'hFFFF_0000,
                               30'($urandom));
        end
        else if (pick < 5)
        begin
            return make_search(lcgsr_pkg::FUNC_IV, s & 32'h7FFF_0000, c1 & 32'h7FFF_0000,
                               30'($urandom));
        end
        else if (pick < 7)
        begin
            return make_search(lcgsr_pkg::FUNC_CHANNEL, $urandom, $urandom,
                {s[31:27], c1[31:27], c2[31:27], c4[31:27], c5[31:27], c3[31:27]});
        end
        return make_search(f, $urandom, $urandom, 30'($urandom));
    endfunction

    task automatic drain();
        while (pending_searches.size() != 0 || in_valid || expected_seeds.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_constant_set(input logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        constant_set <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        set_sel = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sample acceptance of the search in flight.
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (in_valid && !in_stall)
            predict_search(drive_item);
    end

    // Search driver: bursts of transfers with random gaps.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0 || pending_searches.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                drive_item = pending_searches.pop_front();
                in_valid <= 1'b1;
                func <= drive_item.func;
                first_call <= drive_item.first_call;
                second_call <= drive_item.second_call;
                value_hp <= drive_item.hp;
                value_atk <= drive_item.atk;
                value_def <= drive_item.def;
                value_spa <= drive_item.spa;
                value_spd <= drive_item.spd;
                value_spe <= drive_item.spe;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // Result stall pattern: random stalls at a density drawn anew from 0, 30 and 75 percent.
    always @(negedge clk)
    begin
        stall_cycles++;
        if (stall_cycles >= 300)
        begin
            stall_cycles = 0;
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 30;
                default: stall_pct = 75;
            endcase
        end
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        seed_result_t want;
        if (out_valid && !out_stall)
        begin
            if (expected_seeds.size() == 0)
            begin
                $display("%0t: unexpected result found=%0b seed=%h", $time, found, seed);
                errors++;
            end
            else
            begin
                want = expected_seeds.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found exp %0b got %0b", $time, want.found, found);
                    errors++;
                end
                if (seed !== want.seed)
                begin
                    $display("%0t: seed exp %h got %h", $time, want.seed, seed);
                    errors++;
                end
                if (next_seed !== want.next_seed)
                begin
                    $display("%0t: next_seed exp %h got %h", $time, want.next_seed, next_seed);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last exp %0b got %0b", $time, want.last, last);
                    errors++;
                end
                if (overflow !== want.overflow)
                begin
                    $display("%0t: overflow exp %0b got %0b", $time, want.overflow, overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_lcg_truncated_seed_recovery_core failed");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] s;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        constant_set = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        func = lcgsr_pkg::FUNC_IV;
        first_call = '0;
        second_call = '0;
        value_hp = '0;
        value_atk = '0;
        value_def = '0;
        value_spa = '0;
        value_spd = '0;
        value_spe = '0;
        in_taken = 1'b0;
        set_sel = 1'b0;
        errors = 0;
        idle_cycles = 0;
        burst_left = 4;
        gap_left = 0;
        stall_pct = 0;
        stall_cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_constant_set(1'b0);

        // directed: extremes of each search kind, unused code, seeded searches
        for (int f = 0; f < 4; f++)
        begin
            add_search(make_search(2'(f), 32'd0, 32'd0, 30'd0));
            add_search(make_search(2'(f), '1, '1, '1));
            add_search(make_search(2'(f), 32'h8000_0000, 32'h7FFF_FFFF, 30'h2AAA_AAAA));
        end
        s = 32'h1234_5678;
        add_search(make_search(lcgsr_pkg::FUNC_PID, s & 32'hFFFF_0000,
                               step_seed(s) & 32'hFFFF_0000, 30'd0));
        add_search(make_search(lcgsr_pkg::FUNC_IV, s & 32'h7FFF_0000,
                               step_seed(s) & 32'h7FFF_0000, 30'd0));
        for (int i = 0; i < 8; i++)
            add_search(random_search());
        drain();

        for (int i = 0; i < 160; i++)
            add_search(random_search());
        drain();

        // five-step set: one long PID walk that saturates, plus the unused code
        write_constant_set(1'b1);
        s = $urandom;
        add_search(make_search(lcgsr_pkg::FUNC_PID, s & 32'hFFFF_0000,
                               step_seed(s) & 32'hFFFF_0000, 30'($urandom)));
        add_search(make_search(lcgsr_pkg::FUNC_UNUSED, $urandom, $urandom, 30'($urandom)));
        drain();

        write_constant_set(1'b0);
        for (int i = 0; i < 170; i++)
            add_search(random_search());
        drain();

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_lcg_truncated_seed_recovery_core passed");
        else
            $display("tb_lcg_truncated_seed_recovery_core failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/lcgsr_pkg.sv
hdl/lcgsr_datapath.sv
hdl/lcgsr_ctrl.sv
hdl/lcg_truncated_seed_recovery_core.sv
hdl/lcgsr_checker.sv
dv/tb_lcg_truncated_seed_recovery_core.sv
